[design/sem_pkg.sv]
// shared types, constants and helpers for the sobel edge magnitude block
package sem_pkg;

  localparam int PIX_W = 24;
  localparam int CMP_W = 14;
  localparam int SQ_W = 21;
  localparam int ROOT_W = 8;
  localparam int ABS_W = 10;
  localparam int MAX_HEIGHT = 4096;
  localparam logic [SQ_W-1:0] SAT_SQ = SQ_W'(65281);

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pixel_t;

  // absolute difference of two kernel half sums
  function automatic logic [ABS_W-1:0] abs_diff(input logic [ABS_W-1:0] a,
                                                input logic [ABS_W-1:0] b);
    logic [ABS_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

[design/sem_sqrt.sv]
// bit-serial rounded square root with saturation at 255
module sem_sqrt
  import sem_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   sq_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              busy_q, rnd_q, done_q, sat_q;
  logic [2:0]        cnt_q;
  logic [SQ_W-1:0]   s_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] trial;
  logic [15:0]       trial_sq;
  logic [15:0]       root_sq;
  logic [SQ_W-1:0]   half_up;

  assign trial    = root_q | (ROOT_W'(8'h80) >> cnt_q);
  assign trial_sq = 16'(trial) * 16'(trial);
  assign root_sq  = 16'(root_q) * 16'(root_q);
  assign half_up  = SQ_W'(root_sq) + SQ_W'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q    <= sq_i;
      sat_q  <= (sq_i >= SAT_SQ);
      root_q <= '0;
    end else if (busy_q) begin
      if (SQ_W'(trial_sq) <= s_q) begin
        root_q <= trial;
      end
    end else if (rnd_q) begin
      if (sat_q) begin
        root_q <= ROOT_W'(255);
      end else if (s_q > half_up) begin
        root_q <= root_q + ROOT_W'(1);
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[design/sobel_edge_magnitude_rgb.sv]
// top level: line memory, window, sequencer and three magnitude units
//
//  channel | signals                                        | direction
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | write
//  in      | in_valid_i in_ready_o in_blue_i in_green_i ... | pixel in
//  out     | out_valid_o out_ready_i out_blue_o ...         | magnitude out
//
// each pixel releases 0 to 4 results, computed one after another by the bit-serial
// square roots, which are shared across the results
// line memory holds the two rows above, read then written back at the column
// reset and any width or height write restart the frame; no clearing pass is needed
// a stalled output holds the sequencer; no new pixel is taken until all results leave
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_blue_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_red_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_red_o,
  output logic        last_in_run_o,
  output logic        end_of_frame_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [AW-1:0] col_q;
  logic [11:0] row_q;
  logic [3:0]  mask_q, mask_d;
  logic [1:0]  idx_q, idx_d;
  pixel_t      px_q;
  pixel_t      win_q [9];
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic [CMP_W-1:0] w_ext, eff_w;
  logic [12:0]      eff_h;
  logic             last_col, last_row;
  pixel_t           top, mid;
  logic             cfg_we, in_acc, out_acc, upd;

  logic [ABS_W-1:0] ax_q [3];
  logic [ABS_W-1:0] ay_q [3];
  logic [ABS_W-1:0] ax_d [3];
  logic [ABS_W-1:0] ay_d [3];
  logic [SQ_W-1:0]  sq   [3];
  logic [ROOT_W-1:0] root [3];
  logic [2:0]        done;
  logic              start;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && out_ready_i;
  assign upd         = (state_q == S_UPD);
  assign start       = (state_q == S_SQ);

  assign w_ext = CMP_W'(width_q);
  assign eff_w = (w_ext == '0) ? CMP_W'(1)
               : ((w_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_ext);
  assign eff_h = (height_q == '0) ? 13'd1
               : ((height_q > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_q);
  assign last_col = (CMP_W'(col_q) == eff_w - CMP_W'(1));
  assign last_row = ({1'b0, row_q} == eff_h - 13'd1);

  assign top = (row_q >= 12'd2) ? rd_q[2*PIX_W-1:PIX_W] : '0;
  assign mid = (row_q >= 12'd1) ? rd_q[PIX_W-1:0] : '0;

  // line memory: entry holds {row above previous, previous row}
  always_ff @(posedge clk_i) begin
    if (upd) begin
      mem[col_q] <= {mid, px_q};
    end
    rd_q <= mem[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 13'd480;
      col_q    <= '0;
      row_q    <= '0;
      state_q  <= S_IDLE;
      mask_q   <= '0;
      idx_q    <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      idx_q   <= idx_d;
      if (cfg_we && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT)) begin
        if (cfg_index_i == CFG_WIDTH) begin
          width_q <= cfg_data_i[11:0];
        end else begin
          height_q <= cfg_data_i;
        end
        col_q <= '0;
        row_q <= '0;
        for (int i = 0; i < 9; i++) begin
          win_q[i] <= '0;
        end
      end else if (upd) begin
        for (int y = 0; y < 3; y++) begin
          if (col_q == '0) begin
            win_q[y*3]   <= '0;
            win_q[y*3+1] <= '0;
          end else begin
            win_q[y*3]   <= win_q[y*3+1];
            win_q[y*3+1] <= win_q[y*3+2];
          end
        end
        win_q[2] <= top;
        win_q[5] <= mid;
        win_q[8] <= px_q;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 12'd0 : row_q + 12'd1;
        end else begin
          col_q <= col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= {in_red_i, in_green_i, in_blue_i};
    end
    if (state_q == S_CALC) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  // neighborhood for the selected output pixel and its kernel sums
  always_comb begin
    int yy, xx;
    logic [7:0] nb [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          yy = y + int'(idx_q[1]);
          xx = x + int'(idx_q[0]);
          if (yy > 2 || xx > 2) begin
            nb[y][x] = '0;
          end else begin
            nb[y][x] = win_q[yy*3+xx][8*ch +: 8];
          end
        end
      end
      ax_d[ch] = abs_diff(ABS_W'(nb[0][2]) + (ABS_W'(nb[1][2]) << 1) + ABS_W'(nb[2][2]),
                          ABS_W'(nb[0][0]) + (ABS_W'(nb[1][0]) << 1) + ABS_W'(nb[2][0]));
      ay_d[ch] = abs_diff(ABS_W'(nb[2][0]) + (ABS_W'(nb[2][1]) << 1) + ABS_W'(nb[2][2]),
                          ABS_W'(nb[0][0]) + (ABS_W'(nb[0][1]) << 1) + ABS_W'(nb[0][2]));
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_mag
    assign sq[ch] = SQ_W'(SQ_W'(ax_q[ch]) * SQ_W'(ax_q[ch]))
                  + SQ_W'(SQ_W'(ay_q[ch]) * SQ_W'(ay_q[ch]));
    sem_sqrt u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start),
      .sq_i    (sq[ch]),
      .done_o  (done[ch]),
      .root_o  (root[ch])
    );
  end

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        mask_d = {last_row && last_col, last_row && (col_q != '0),
                  (row_q != '0) && last_col, (row_q != '0) && (col_q != '0)};
        state_d = (mask_d == '0) ? S_IDLE : S_CALC;
      end
      S_CALC: begin
        state_d = S_SQ;
      end
      S_SQ: begin
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (done[0]) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          mask_d = mask_q & ~(4'b0001 << idx_q);
          state_d = (mask_d == '0) ? S_IDLE : S_CALC;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // lowest pending result goes next
    if (state_d == S_CALC) begin
      if (mask_d[0]) begin
        idx_d = 2'd0;
      end else if (mask_d[1]) begin
        idx_d = 2'd1;
      end else if (mask_d[2]) begin
        idx_d = 2'd2;
      end else begin
        idx_d = 2'd3;
      end
    end
  end

  assign out_blue_o     = root[0];
  assign out_green_o    = root[1];
  assign out_red_o      = root[2];
  assign last_in_run_o  = ((mask_q & ~(4'b0001 << idx_q)) == '0);
  assign end_of_frame_o = (idx_q == 2'd3);

  a_out_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (mask_q != '0))
    else $error("result offered with nothing pending");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("pixel taken while a result waits");
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && last_col) |=> (col_q == '0))
    else $error("column did not wrap at end of row");
  a_roots_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done != '0) |-> (done == 3'b111))
    else $error("magnitude units out of step");

endmodule

[tb/sv/sobel_edge_magnitude_rgb_tb.sv]
// testbench for the rgb sobel edge magnitude block: directed table, random frames, predictor
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;

  localparam int MAX_W = 2048;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_in_run;
    logic       eof;
  } magnitude_t;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] index;
    logic [12:0] data;
    pixel_t     pix;
    bit         typed;
    int         n_typed;
    magnitude_t mag;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_blue_i;
  logic [7:0]  in_green_i;
  logic [7:0]  in_red_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_red_o;
  logic        last_in_run_o;
  logic        end_of_frame_o;

  sobel_edge_magnitude_rgb #(.MAX_WIDTH(MAX_W)) i_dut (.*);

  // predictor state
  pixel_t line_mem[2*MAX_W];
  pixel_t win[9];
  int unsigned col_cnt, row_cnt, width_reg, height_reg;
  magnitude_t pending_mags[$];
  int errors;
  bit idle_en;
  int stall_left;

  function automatic int tap(int y, int x, int dy, int dx, int sh);
    int yy, xx;
    yy = y + dy;
    xx = x + dx;
    if (yy > 2 || xx > 2) return 0;
    return int'((win[yy*3+xx] >> sh) & 24'hff);
  endfunction

  function automatic logic [7:0] edge_strength(int dy, int dx, int sh);
    int gx, gy;
    int unsigned s, n;
    gx = (tap(0, 2, dy, dx, sh) + 2 * tap(1, 2, dy, dx, sh) + tap(2, 2, dy, dx, sh))
       - (tap(0, 0, dy, dx, sh) + 2 * tap(1, 0, dy, dx, sh) + tap(2, 0, dy, dx, sh));
    gy = (tap(2, 0, dy, dx, sh) + 2 * tap(2, 1, dy, dx, sh) + tap(2, 2, dy, dx, sh))
       - (tap(0, 0, dy, dx, sh) + 2 * tap(0, 1, dy, dx, sh) + tap(0, 2, dy, dx, sh));
    s = gx * gx + gy * gy;
    if (s >= 65281) return 8'd255;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return n[7:0];
  endfunction

  function automatic void push_mag(int dy, int dx, bit eof);
    magnitude_t m;
    m.blue = edge_strength(dy, dx, 0);
    m.green = edge_strength(dy, dx, 8);
    m.red = edge_strength(dy, dx, 16);
    m.last_in_run = 1'b0;
    m.eof = eof;
    pending_mags.push_back(m);
  endfunction

  function automatic void restart_frame();
    foreach (win[i]) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [12:0] data);
    if (idx == CFG_WIDTH) begin
      width_reg = 32'(data[11:0]);
      restart_frame();
    end else if (idx == CFG_HEIGHT) begin
      height_reg = 32'(data);
      restart_frame();
    end
  endfunction

  function automatic void sobel_predict_pixel(pixel_t p);
    int unsigned w, h, c, r;
    pixel_t top, mid;
    bit last_col, last_row;
    int k;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    c = (col_cnt >= w) ? 0 : col_cnt;
    r = (row_cnt >= h) ? 0 : row_cnt;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    top = (r >= 2) ? line_mem[c] : '0;
    mid = (r >= 1) ? line_mem[MAX_W + c] : '0;
    line_mem[c] = mid;
    line_mem[MAX_W + c] = p;
    for (int y = 0; y < 3; y++) begin
      if (c == 0) begin
        win[y*3] = '0;
        win[y*3+1] = '0;
      end else begin
        win[y*3] = win[y*3+1];
        win[y*3+1] = win[y*3+2];
      end
    end
    win[2] = top;
    win[5] = mid;
    win[8] = p;
    k = 0;
    if (r >= 1) begin
      if (c >= 1) begin push_mag(0, 0, 0); k++; end
      if (last_col) begin push_mag(0, 1, 0); k++; end
    end
    if (last_row) begin
      if (c >= 1) begin push_mag(1, 0, 0); k++; end
      if (last_col) begin push_mag(1, 1, 1); k++; end
    end
    if (k > 0) pending_mags[$].last_in_run = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  function automatic int gap_len();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 3))
        0: p[ch*8 +: 8] = 8'h00;
        1: p[ch*8 +: 8] = 8'hff;
        default: p[ch*8 +: 8] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {in_red_i, in_green_i, in_blue_i} <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sobel_predict_pixel(p);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_mags.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_frame(logic [12:0] w, logic [12:0] h, int count);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 2) wait_drained();
      send_pixel(rand_pixel());
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, a few long ones
  always @(posedge clk_i) begin : ready_gen
    int r;
    r = $urandom_range(0, 99);
    if (!rst_ni) begin
      stall_left <= 0;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else begin
      if (r < 3) stall_left <= $urandom_range(10, 40);
      out_ready_i <= (r >= 30);
    end
  end

  always @(posedge clk_i) begin : mag_check
    magnitude_t m;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mags.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        m = pending_mags.pop_front();
        if (out_blue_o !== m.blue) begin
          $error("out_blue expected %0d actual %0d", m.blue, out_blue_o);
          errors++;
        end
        if (out_green_o !== m.green) begin
          $error("out_green expected %0d actual %0d", m.green, out_green_o);
          errors++;
        end
        if (out_red_o !== m.red) begin
          $error("out_red expected %0d actual %0d", m.red, out_red_o);
          errors++;
        end
        if (last_in_run_o !== m.last_in_run) begin
          $error("last_in_run expected %0b actual %0b", m.last_in_run, last_in_run_o);
          errors++;
        end
        if (end_of_frame_o !== m.eof) begin
          $error("end_of_frame expected %0b actual %0b", m.eof, end_of_frame_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t sr;
    magnitude_t zero_eof;
    int n_prior, fcount, wv, hv;
    idle_en = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_blue_i = '0;
    in_green_i = '0;
    in_red_i = '0;
    width_reg = 640;
    height_reg = 480;
    foreach (line_mem[i]) line_mem[i] = '0;
    restart_frame();
    zero_eof = '{blue: 8'd0, green: 8'd0, red: 8'd0, last_in_run: 1'b1, eof: 1'b1};

    // after reset the frame is 640x480, so the top row gives nothing
    rows.push_back('{ROW_PIXEL, 2'd0, 13'd0, 24'h000000, 1, 0, '0});
    rows.push_back('{ROW_PIXEL, 2'd0, 13'd0, 24'hffffff, 1, 0, '0});
    rows.push_back('{ROW_REG, CFG_SPARE_A, 13'd5, '0, 0, 0, '0});
    rows.push_back('{ROW_PIXEL, 2'd0, 13'd0, 24'h5a5a5a, 1, 0, '0});
    // zero width and height act as a single pixel frame
    rows.push_back('{ROW_REG, CFG_WIDTH, 13'd0, '0, 0, 0, '0});
    rows.push_back('{ROW_REG, CFG_HEIGHT, 13'd0, '0, 0, 0, '0});
    rows.push_back('{ROW_PIXEL, 2'd0, 13'd0, 24'hffffff, 1, 1, zero_eof});
    rows.push_back('{ROW_PIXEL, 2'd0, 13'd0, 24'h000000, 1, 1, zero_eof});
    // bit 12 of the width write is dropped, giving width 2
    rows.push_back('{ROW_REG, CFG_WIDTH, 13'h1002, '0, 0, 0, '0});
    rows.push_back('{ROW_REG, CFG_HEIGHT, 13'd3, '0, 0, 0, '0});
    for (int i = 0; i < 6; i++)
      rows.push_back('{ROW_PIXEL, 2'd0, 13'd0, (i % 2) ? 24'h000000 : 24'hffffff, 0, 0, '0});
    rows.push_back('{ROW_REG, CFG_WIDTH, 13'd3, '0, 0, 0, '0});
    rows.push_back('{ROW_REG, CFG_HEIGHT, 13'd3, '0, 0, 0, '0});
    for (int i = 0; i < 9; i++)
      rows.push_back('{ROW_PIXEL, 2'd0, 13'd0,
                       (i % 3 == 0) ? 24'hff00ff : 24'h00ff00, 0, 0, '0});
    rows.push_back('{ROW_REG, CFG_SPARE_B, 13'h1fff, '0, 0, 0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      sr = rows[i];
      if (sr.kind == ROW_REG) begin
        write_reg(sr.index, sr.data);
      end else begin
        if (sr.typed) wait_drained();
        n_prior = pending_mags.size();
        send_pixel(sr.pix);
        if (sr.typed) begin
          while (pending_mags.size() > n_prior) void'(pending_mags.pop_back());
          if (sr.n_typed > 0) pending_mags.push_back(sr.mag);
        end
      end
    end
    wait_drained();

    // largest sizes; oversize writes clamp to the limits
    run_frame(13'd4095, 13'd2, 30);
    run_frame(13'd1, 13'd8191, 30);
    run_frame(13'd2048, 13'd1, 30);

    idle_en = 1'b1;
    fcount = 0;
    while (fcount < 130) begin
      idle_en = ($urandom_range(0, 4) != 0);
      wv = $urandom_range(1, 8);
      hv = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        run_frame(13'(wv), 13'(hv), $urandom_range(0, wv * hv));
        fcount += wv * hv / 2;
      end else begin
        run_frame(13'(wv), 13'(hv), wv * hv * $urandom_range(1, 2));
        fcount += wv * hv;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_mags.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/sem_pkg.sv
design/sem_sqrt.sv
design/sobel_edge_magnitude_rgb.sv
tb/sv/sobel_edge_magnitude_rgb_tb.sv
